// File: hw/rtl/sliding_window_median_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Concurrent assertion helpers, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`else

`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median package
// Widths, reset values and the controller to datapath command and status types.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_W    = 32;
  localparam int IDX_W       = $clog2(WINDOW_MAX);
  localparam int LEN_W       = 5;
  localparam int OUT_W       = SAMPLE_W + 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 5'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_REM_CMP,
    ST_REM_SHIFT,
    ST_INS_CMP,
    ST_INS_SHIFT,
    ST_EMIT
  } swm_state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic rem_cmp;
    logic rem_shift;
    logic ins_cmp;
    logic ins_shift;
    logic emit;
  } swm_cmd_t;

  typedef struct packed {
    logic full;
    logic result;
    logic out_free;
  } swm_sts_t;

endpackage

// File: hw/rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median of a signed sample stream over a configurable window.
// ----------------------------------------------------------------------------
// Samples arrive on the in_ stream, one transaction per sample: tdata carries
// the signed 32-bit sample, tuser bit 0 opens a new sequence and empties the
// window first. Each completed window yields one transaction on the out_
// stream carrying twice the median as a signed 33-bit value; the first
// window_len-1 samples of a sequence produce none. The cfg_ channel writes
// the window length (1 to 16) and empties the window; write it only while
// the block is idle. A length of zero acts as one, above 16 as 16.
// One sample is processed at a time. An accepted sample passes through a
// decide step, a removal pass when the window is full, an insertion pass
// and, when it completes a window, an emit step that loads the output
// register; the removal and insertion passes over the sorted cell row each
// have a compare step and a shift step. The next sample is accepted once
// the block is back in its idle state.
// Reset empties the window and sets the length to 3. A stalled receiver
// holds the result in the output register; the block takes the next sample
// meanwhile but waits before replacing an untaken result.
// ----------------------------------------------------------------------------
module sliding_window_median
  import swm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample
  input  logic [0:0]             in_tuser,   // [0] start_req
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [32:0] median_x2, [39:33] zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LEN_W-1:0]       cfg_data    // [4:0] window_len
);

  swm_cmd_t         cmd;
  swm_sts_t         sts;
  logic [OUT_W-1:0] out_median;

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_median};

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .in_start   (in_tuser[0]),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_median (out_median),
    .out_tready (out_tready)
  );

endmodule

// File: hw/rtl/swm_datapath.sv
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"
// ----------------------------------------------------------------------------
// Sliding window median datapath
// Arrival ring, sorted cell row, window counters and the output register.
// ----------------------------------------------------------------------------
module swm_datapath
  import swm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  swm_cmd_t               cmd,
  output swm_sts_t               sts,
  input  logic [SAMPLE_W-1:0]    in_sample,
  input  logic                   in_start,
  input  logic                   cfg_wr,
  input  logic [LEN_W-1:0]       cfg_data,
  output logic                   out_tvalid,
  output logic [OUT_W-1:0]       out_median,
  input  logic                   out_tready
);

  logic [LEN_W-1:0]           window_len_r;
  logic [LEN_W-1:0]           len_eff;
  logic [LEN_W-1:0]           fill_r;
  logic [IDX_W-1:0]           ptr_r;
  logic                       full_r;
  logic [LEN_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] ring_r   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sorted_r [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sorted_nxt [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] up_w [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] dn_w [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      mask_r;
  logic [WINDOW_MAX-1:0]      mask_nxt;
  logic [WINDOW_MAX-1:0]      mask_dn;
  logic signed [SAMPLE_W-1:0] oldest_r;
  logic [IDX_W-1:0]           lo_idx;
  logic [IDX_W-1:0]           hi_idx;
  logic signed [OUT_W-1:0]    median_sum;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;

  // A length of zero behaves as one, anything above the store depth as the depth.
  always_comb begin
    if (window_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_len_r > LEN_W'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = window_len_r;
    end
  end

  // Neighbour views of the sorted row, used by the shifting steps.
  always_comb begin
    for (int j = 0; j < WINDOW_MAX - 1; j++) begin
      up_w[j] = sorted_r[j+1];
    end
    up_w[WINDOW_MAX-1] = sorted_r[WINDOW_MAX-1];
    dn_w[0]    = sorted_r[0];
    mask_dn[0] = 1'b0;
    for (int j = 1; j < WINDOW_MAX; j++) begin
      dn_w[j]    = sorted_r[j-1];
      mask_dn[j] = mask_r[j-1];
    end
  end

  // Compare masks: equality with the oldest sample on removal, and
  // greater-than the new sample on insertion.
  always_comb begin
    mask_nxt = mask_r;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (cmd.rem_cmp) begin
        mask_nxt[i] = (LEN_W'(i) < len_eff) && (sorted_r[i] == oldest_r);
      end else if (cmd.ins_cmp) begin
        mask_nxt[i] = (LEN_W'(i) < cnt_r) && (sample_r < sorted_r[i]);
      end
    end
  end

  // Removal closes the gap from the first match upwards; insertion opens a
  // slot above the last entry not greater than the new sample.
  always_comb begin
    logic run;
    logic here;
    run = 1'b0;
    here = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted_nxt[i] = sorted_r[i];
      if (cmd.rem_shift) begin
        run = run | mask_r[i];
        if (run && (LEN_W'(i + 1) < len_eff)) begin
          sorted_nxt[i] = up_w[i];
        end
      end else if (cmd.ins_shift) begin
        here = (LEN_W'(i) < cnt_r) ? mask_r[i] : (LEN_W'(i) == cnt_r);
        if (here) begin
          sorted_nxt[i] = mask_dn[i] ? dn_w[i] : sample_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted_r[i] <= sorted_nxt[i];
    end
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.decide) begin
      full_r   <= sts.full;
      cnt_r    <= sts.full ? (len_eff - LEN_W'(1)) : fill_r;
      oldest_r <= ring_r[ptr_r];
    end
    if (cmd.ins_shift) begin
      if (full_r) begin
        ring_r[ptr_r] <= sample_r;
      end else begin
        ring_r[fill_r[IDX_W-1:0]] <= sample_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RESET;
      fill_r       <= '0;
      ptr_r        <= '0;
    end else if (cfg_wr) begin
      window_len_r <= cfg_data;
      fill_r       <= '0;
      ptr_r        <= '0;
    end else if (cmd.load && in_start) begin
      fill_r <= '0;
      ptr_r  <= '0;
    end else if (cmd.ins_shift) begin
      if (full_r) begin
        ptr_r <= (LEN_W'(ptr_r) + LEN_W'(1) == len_eff) ? '0 : ptr_r + IDX_W'(1);
      end else begin
        fill_r <= fill_r + LEN_W'(1);
        ptr_r  <= '0;
      end
    end
  end

  // The two middle entries coincide for an odd window, giving twice the median.
  always_comb begin
    lo_idx     = IDX_W'((len_eff - LEN_W'(1)) >> 1);
    hi_idx     = IDX_W'(len_eff >> 1);
    median_sum = OUT_W'(sorted_r[lo_idx]) + OUT_W'(sorted_r[hi_idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= median_sum;
    end
  end

  assign sts.full     = (fill_r >= len_eff);
  assign sts.result   = full_r || ((fill_r + LEN_W'(1)) == len_eff);
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_median   = out_data_r;

  `SWM_ASSERT_IMP(a_fill_in_window, clk, rst_n, 1'b1, (fill_r <= len_eff))
  `SWM_ASSERT_IMP(a_ptr_in_window, clk, rst_n, 1'b1, (LEN_W'(ptr_r) < len_eff))
  `SWM_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_wr, ((fill_r == '0) && (ptr_r == '0)))

endmodule

// File: hw/rtl/swm_ctrl.sv
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"
// ----------------------------------------------------------------------------
// Sliding window median controller
// Steps each sample through removal, insertion and result hand-off.
// ----------------------------------------------------------------------------
module swm_ctrl
  import swm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  swm_state_t state_r;
  swm_state_t state_nxt;
  logic       accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.full ? ST_REM_CMP : ST_INS_CMP;
      end
      ST_REM_CMP:   state_nxt = ST_REM_SHIFT;
      ST_REM_SHIFT: state_nxt = ST_INS_CMP;
      ST_INS_CMP:   state_nxt = ST_INS_SHIFT;
      ST_INS_SHIFT: begin
        state_nxt = sts.result ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECIDE:    cmd.decide    = 1'b1;
      ST_REM_CMP:   cmd.rem_cmp   = 1'b1;
      ST_REM_SHIFT: cmd.rem_shift = 1'b1;
      ST_INS_CMP:   cmd.ins_cmp   = 1'b1;
      ST_INS_SHIFT: cmd.ins_shift = 1'b1;
      ST_EMIT:      cmd.emit      = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `SWM_ASSERT_NEXT(a_accept_to_decide, clk, rst_n, accept, (state_r == ST_DECIDE))
  `SWM_ASSERT_NEXT(a_silent_to_idle, clk, rst_n, ((state_r == ST_INS_SHIFT) && !sts.result), (state_r == ST_IDLE))
  `SWM_ASSERT_NEXT(a_emit_to_idle, clk, rst_n, cmd.emit, (state_r == ST_IDLE))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Drives signed samples and window lengths into the filter and checks each
// result transaction against a running software model of the window.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  localparam int GAP_MAX    = 19;
  localparam int DRAIN_WAIT = 12;   // longest sample that gives no result, with margin
  localparam int PHASE_LEN  = 85;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] sample
  logic [0:0]             in_tuser;   // [0] start_req
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [32:0] median_x2, [39:33] zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data;

  sliding_window_median dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Window model state
  logic [LEN_W-1:0]           win_len;
  logic signed [SAMPLE_W-1:0] arrival[WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] ordered[WINDOW_MAX];
  int                         fill_cnt;
  int                         oldest_slot;

  logic [OUT_W-1:0] median_q[$];
  int               fail_count;
  int               in_gap_max;
  int               out_gap_max;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int active_len();
    if (win_len == 0) return 1;
    if (win_len > WINDOW_MAX) return WINDOW_MAX;
    return int'(win_len);
  endfunction

  function automatic void insert_ordered(input logic signed [SAMPLE_W-1:0] v, input int count);
    int i;
    i = count;
    while (i > 0 && v < ordered[i-1]) begin
      ordered[i] = ordered[i-1];
      i--;
    end
    ordered[i] = v;
  endfunction

  // Advances the window by one sample; returns 1 when a median is due.
  function automatic bit median_step(input logic signed [SAMPLE_W-1:0] s, input logic start,
                                     output logic [OUT_W-1:0] med);
    int len;
    int slot;
    int pos;
    int k;
    len = active_len();
    if (start) begin
      fill_cnt    = 0;
      oldest_slot = 0;
    end
    if (fill_cnt >= len) begin
      slot = oldest_slot % len;
      // Duplicates are separate entries, so only the first equal one leaves.
      pos = len - 1;
      for (int i = 0; i < len; i++) begin
        if (ordered[i] == arrival[slot]) begin
          pos = i;
          break;
        end
      end
      for (int i = pos; i + 1 < len; i++) ordered[i] = ordered[i+1];
      insert_ordered(s, len - 1);
      arrival[slot] = s;
      oldest_slot   = (slot + 1) % len;
    end else begin
      arrival[fill_cnt] = s;
      insert_ordered(s, fill_cnt);
      fill_cnt++;
      oldest_slot = 0;
      if (fill_cnt < len) return 1'b0;
    end
    k = len / 2;
    if (len % 2)
      med = {ordered[k][SAMPLE_W-1], ordered[k]} + {ordered[k][SAMPLE_W-1], ordered[k]};
    else
      med = {ordered[k-1][SAMPLE_W-1], ordered[k-1]} + {ordered[k][SAMPLE_W-1], ordered[k]};
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
    if (pick < 6) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
        1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic start);
    int gap;
    logic [OUT_W-1:0] med;
    gap = (in_gap_max > 0) ? int'($urandom_range(0, in_gap_max)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    if (median_step(s, start, med)) median_q = {median_q, med};
  endtask

  // Stops the input stream and lets every outstanding result arrive.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [LEN_W-1:0] len);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    win_len     = len;
    fill_cnt    = 0;
    oldest_slot = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Length 3 from reset: extremes, duplicates and restarts mid-fill and when full.
  task automatic test_reset_length();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0005, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0007, 1'b1);
    send_sample(32'h0000_0009, 1'b0);
    send_sample(32'h0000_0008, 1'b0);
  endtask

  // Lengths of one and zero pass each sample through doubled.
  task automatic test_unit_window();
    write_window_len(5'd1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    write_window_len(5'd0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h5555_aaaa, 1'b0);
  endtask

  // Even window: the result is the sum of the two middle entries.
  task automatic test_even_window();
    write_window_len(5'd2);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
  endtask

  // Random samples over many lengths, including out-of-range ones, with
  // stalls switched on and off per phase.
  task automatic test_random_phases();
    logic [LEN_W-1:0] lens[] = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd4, 5'd15, 5'd8, 5'd17, 5'd7,
                                 5'd1, 5'd0, 5'd6, 5'd9, 5'd12, 5'd3, 5'd10, 5'd11,
                                 5'd13, 5'd14};
    for (int ph = 0; ph < lens.size(); ph++) begin
      write_window_len(lens[ph]);
      in_gap_max  = (ph % 4 == 1 || ph % 4 == 3) ? GAP_MAX : 0;
      out_gap_max = (ph % 4 >= 2) ? GAP_MAX : 0;
      for (int n = 0; n < PHASE_LEN; n++)
        send_sample(rand_sample(), $urandom_range(0, 31) == 0);
    end
  endtask

  // Receiver: waits a drawn number of cycles before taking each result.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = (out_gap_max > 0) ? int'($urandom_range(0, out_gap_max)) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        if (out_tdata !== {{(OUT_TDATA_W-OUT_W){1'b0}}, median_q[0]}) begin
          $display("%0t: median mismatch, expected %h (%0d), actual %h (%0d)", $time,
                   median_q[0], $signed(median_q[0]), out_tdata,
                   $signed(out_tdata[OUT_W-1:0]));
          fail_count++;
        end
        void'(median_q.pop_front());
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    fail_count  = 0;
    in_gap_max  = 0;
    out_gap_max = 0;
    win_len     = WINDOW_LEN_RESET;
    fill_cnt    = 0;
    oldest_slot = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_length();
    test_unit_window();
    test_even_window();
    test_random_phases();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && median_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_datapath.sv
hw/rtl/swm_ctrl.sv
hw/rtl/sliding_window_median.sv
tb/tb_top.sv
